@@ design/mrw_pkg.sv @@
`default_nettype none
package mrw_pkg;
    localparam int WIDTH = 64;
    localparam int CW = $clog2(WIDTH + 1);

    localparam logic [1:0] VERDICT_NONE    = 2'd0;
    localparam logic [1:0] VERDICT_WITNESS = 2'd1;
    localparam logic [1:0] VERDICT_PRIME   = 2'd2;
    localparam logic [1:0] VERDICT_COMPOS  = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_MUL  = 2'd1,
        OP_SQR  = 2'd2,
        OP_REDA = 2'd3
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic            done;
        logic            trivial;
        logic [1:0]      trivial_verdict;
        logic            exp_bit;
        logic            acc_is_one;
        logic            prev_ok;
        logic [CW-1:0]   r_count;
        logic [CW-1:0]   top_bit;
    } dp_sts_t;
endpackage
`default_nettype wire

@@ design/mrw_datapath.sv @@
`default_nettype none
module mrw_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire logic [mrw_pkg::WIDTH-1:0]  n_in,
    input  wire logic [mrw_pkg::WIDTH-1:0]  a_in,
    input  wire mrw_pkg::dp_cmd_t           cmd,
    input  wire logic [mrw_pkg::CW-1:0]     bit_idx,
    output mrw_pkg::dp_sts_t                sts
);
    localparam int W = mrw_pkg::WIDTH;
    localparam int CW = mrw_pkg::CW;

    logic [W-1:0]  n_reg, u_reg, am_reg, acc_reg, prev_reg, x_reg, y_reg;
    logic [W:0]    sum_reg;
    logic [CW-1:0] i_reg, r_reg, top_reg;
    logic          busy_reg, done_reg, red_reg;
    logic [W-1:0]  nm1;
    logic [W:0]    dbl, dsub, add1, asub;
    logic [W-1:0]  step1;
    logic [W-1:0]  u_sh;
    logic [W-1:0]  nm1_in;
    logic [W-1:0]  acc_now;
    logic [CW-1:0] r_sh, top_c;

    assign nm1 = n_reg - W'(1);
    assign acc_now = done_reg ? sum_reg[W-1:0] : acc_reg;

    // One bit of the double-and-add modular product each cycle.
    always_comb
    begin
        dbl  = {sum_reg[W-1:0], 1'b0};
        dsub = dbl - {1'b0, n_reg};
        step1 = dsub[W] ? dbl[W-1:0] : dsub[W-1:0];
        add1 = {1'b0, step1} + {1'b0, x_reg};
        asub = add1 - {1'b0, n_reg};
    end

    // Odd part and two-power count of n-1, and the exponent's top bit.
    always_comb
    begin
        nm1_in = n_in - W'(1);
        r_sh = '0;
        for (int k = W - 1; k >= 0; k--)
        begin
            if (nm1_in[k])
            begin
                r_sh = CW'(k);
            end
        end
        u_sh = nm1_in >> r_sh;
        top_c = '0;
        for (int k = 0; k < W; k++)
        begin
            if (u_sh[k])
            begin
                top_c = CW'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && i_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            n_reg   <= n_in;
            am_reg  <= a_in;
            u_reg   <= u_sh;
            r_reg   <= r_sh;
            top_reg <= top_c;
            acc_reg <= W'(1);
        end
        if (cmd.start)
        begin
            sum_reg <= '0;
            i_reg   <= (cmd.op == mrw_pkg::OP_LOAD) ? '0 : CW'(W - 1);
            red_reg <= (cmd.op == mrw_pkg::OP_REDA);
            case (cmd.op)
                mrw_pkg::OP_LOAD:
                begin
                    acc_reg <= W'(1);
                end
                mrw_pkg::OP_MUL:
                begin
                    x_reg <= acc_reg;
                    y_reg <= am_reg;
                end
                mrw_pkg::OP_SQR:
                begin
                    x_reg    <= acc_reg;
                    y_reg    <= acc_reg;
                    prev_reg <= acc_reg;
                end
                mrw_pkg::OP_REDA:
                begin
                    // a mod n as a times 1 mod n, a reduced bit by bit.
                    x_reg <= '0;
                    y_reg <= am_reg;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (red_reg)
            begin
                // Horner reduction of y: sum = 2*sum + bit.
                sum_reg <= step1 + W'(y_reg[i_reg[$clog2(W)-1:0]]) >= n_reg
                           ? {1'b0, step1 + W'(y_reg[i_reg[$clog2(W)-1:0]]) - n_reg}
                           : {1'b0, step1 + W'(y_reg[i_reg[$clog2(W)-1:0]])};
            end
            else if (y_reg[i_reg[$clog2(W)-1:0]])
            begin
                sum_reg <= asub[W] ? add1 : {1'b0, asub[W-1:0]};
            end
            else
            begin
                sum_reg <= {1'b0, step1};
            end
            if (i_reg != '0)
            begin
                i_reg <= i_reg - CW'(1);
            end
        end
        else if (done_reg)
        begin
            if (red_reg)
            begin
                am_reg <= sum_reg[W-1:0];
            end
            else
            begin
                acc_reg <= sum_reg[W-1:0];
            end
        end
    end

    always_comb
    begin
        sts.done = done_reg;
        sts.trivial = 1'b1;
        sts.trivial_verdict = mrw_pkg::VERDICT_COMPOS;
        if (n_reg < W'(2))
        begin
            sts.trivial_verdict = mrw_pkg::VERDICT_COMPOS;
        end
        else if (n_reg == W'(2) || n_reg == W'(3))
        begin
            sts.trivial_verdict = mrw_pkg::VERDICT_PRIME;
        end
        else if (!n_reg[0])
        begin
            sts.trivial_verdict = mrw_pkg::VERDICT_COMPOS;
        end
        else
        begin
            sts.trivial = 1'b0;
        end
        sts.exp_bit    = u_reg[bit_idx[$clog2(W)-1:0]];
        sts.acc_is_one = (acc_now == W'(1));
        sts.prev_ok    = (prev_reg == W'(1)) || (prev_reg == nm1);
        sts.r_count    = r_reg;
        sts.top_bit    = top_reg;
    end
endmodule
`default_nettype wire

@@ design/mrw_control.sv @@
`default_nettype none
module mrw_control (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_fire,
    input  wire logic                    last_in,
    input  wire logic                    out_free,
    input  wire mrw_pkg::dp_sts_t        sts,
    output mrw_pkg::dp_cmd_t             cmd,
    output logic [mrw_pkg::CW-1:0]       bit_idx,
    output logic                         idle,
    output logic                         res_valid,
    output logic [1:0]                   res_verdict,
    output logic                         res_last,
    output logic                         res_prime
);
    localparam int CW = mrw_pkg::CW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CHECK = 8'b00000010,
        S_RED   = 8'b00000100,
        S_SQ    = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_RSQ   = 8'b00100000,
        S_WAIT  = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t        state_reg, ret_reg;
    logic [CW-1:0] idx_reg, k_reg;
    logic          last_reg, seen_reg, issued_reg;
    logic [1:0]    verdict_reg;

    assign bit_idx = idx_reg;
    assign idle = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign res_verdict = verdict_reg;
    assign res_last = last_reg;
    assign res_prime = last_reg && !(seen_reg || verdict_reg == mrw_pkg::VERDICT_WITNESS
                                     || verdict_reg == mrw_pkg::VERDICT_COMPOS);

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op = mrw_pkg::OP_LOAD;
        if (!issued_reg)
        begin
            case (state_reg)
                S_RED:   begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_REDA; end
                S_SQ:    begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_SQR;  end
                S_MUL:   begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_MUL;  end
                S_RSQ:   begin cmd.start = 1'b1; cmd.op = mrw_pkg::OP_SQR;  end
                default: cmd.start = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            seen_reg   <= 1'b0;
            issued_reg <= 1'b0;
            idx_reg    <= '0;
            k_reg      <= '0;
            last_reg   <= 1'b0;
            verdict_reg <= mrw_pkg::VERDICT_NONE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        last_reg  <= last_in;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (sts.trivial)
                    begin
                        verdict_reg <= sts.trivial_verdict;
                        state_reg   <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_RED;
                    end
                end
                S_RED, S_SQ, S_MUL, S_RSQ:
                begin
                    issued_reg <= 1'b1;
                    ret_reg    <= state_reg;
                    state_reg  <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (sts.done)
                    begin
                        issued_reg <= 1'b0;
                        case (ret_reg)
                            S_RED:
                            begin
                                idx_reg   <= sts.top_bit;
                                state_reg <= S_SQ;
                            end
                            S_SQ:
                            begin
                                if (sts.exp_bit)
                                begin
                                    state_reg <= S_MUL;
                                end
                                else if (idx_reg == '0)
                                begin
                                    k_reg <= '0;
                                    state_reg <= S_RSQ;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg - CW'(1);
                                    state_reg <= S_SQ;
                                end
                            end
                            S_MUL:
                            begin
                                if (idx_reg == '0)
                                begin
                                    k_reg <= '0;
                                    state_reg <= S_RSQ;
                                end
                                else
                                begin
                                    idx_reg <= idx_reg - CW'(1);
                                    state_reg <= S_SQ;
                                end
                            end
                            default:
                            begin
                                if (sts.acc_is_one && !sts.prev_ok)
                                begin
                                    verdict_reg <= mrw_pkg::VERDICT_WITNESS;
                                    state_reg <= S_OUT;
                                end
                                else if (k_reg + CW'(1) == sts.r_count)
                                begin
                                    verdict_reg <= sts.acc_is_one ? mrw_pkg::VERDICT_NONE
                                                                  : mrw_pkg::VERDICT_WITNESS;
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    k_reg <= k_reg + CW'(1);
                                    state_reg <= S_RSQ;
                                end
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        seen_reg  <= last_reg ? 1'b0 :
                                     (seen_reg || verdict_reg == mrw_pkg::VERDICT_WITNESS
                                      || verdict_reg == mrw_pkg::VERDICT_COMPOS);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/miller_rabin_witness.sv @@
`default_nettype none
// Miller-Rabin witness round, one request per base.
// The slave channel takes a request: tdata holds candidate in bits 63:0 and
// base in bits 127:64; tlast marks the last base of a test. The master channel
// returns one result per request: tdata holds round_verdict in bits 1:0,
// probably_prime in bit 2, zero fill above; tlast carries test_done.
// Only one request is in flight; s_tready is high while the block is idle.
// Trivial candidates present their result in S_OUT, reached through S_CHECK
// once the request is taken. Otherwise the round runs up to 2*(WIDTH-r)+r
// modular products plus one reduction of the base, all on a single
// bit-serial double-and-add multiplier.
// The result register holds its value while m_tready is low; the next request
// is taken after the result is delivered.
// Reset clears the controller and the sticky composite flag of the open test.
module miller_rabin_witness (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // candidate, base
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,  // round_verdict, probably_prime
    output logic              m_tlast
);
    localparam int W = mrw_pkg::WIDTH;

    mrw_pkg::dp_cmd_t         cmd;
    mrw_pkg::dp_sts_t         sts;
    logic [mrw_pkg::CW-1:0]   bit_idx;
    logic                     idle, in_fire, res_prime;
    logic [1:0]               res_verdict;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && idle;

    mrw_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (in_fire),
        .n_in    (s_tdata[W-1:0]),
        .a_in    (s_tdata[64 +: W]),
        .cmd     (cmd),
        .bit_idx (bit_idx),
        .sts     (sts)
    );

    mrw_control u_ctl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .last_in     (s_tlast),
        .out_free    (m_tready),
        .sts         (sts),
        .cmd         (cmd),
        .bit_idx     (bit_idx),
        .idle        (idle),
        .res_valid   (m_tvalid),
        .res_verdict (res_verdict),
        .res_last    (m_tlast),
        .res_prime   (res_prime)
    );

    assign m_tdata = {5'b0, res_prime, res_verdict};
endmodule
`default_nettype wire

@@ design/mrw_checker.sv @@
`default_nettype none
module mrw_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("request taken while result pending");
    a_prime_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tlast)
        else $error("verdict outside a closed test");
    a_prime_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> (m_tdata[1:0] == mrw_pkg::VERDICT_NONE
                                    || m_tdata[1:0] == mrw_pkg::VERDICT_PRIME))
        else $error("prime with composite round");
endmodule

bind miller_rabin_witness mrw_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

@@ sim/miller_rabin_witness_test.sv @@
`timescale 1ns / 1ps
module miller_rabin_witness_test;
    typedef struct packed {
        logic [1:0] verdict;
        logic       done;
        logic       prime;
    } round_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;
    logic         m_tlast;

    round_result_t expected_results[$];
    logic          composite_flag;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            hold_off_cycles;
    int            mismatches;

    miller_rabin_witness u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
        logic [127:0] p;
        p = {64'd0, x} * {64'd0, y};
        p = p % {64'd0, m};
        return p[63:0];
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e, logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] am;
        acc = 64'd1;
        am = a % m;
        for (int i = 63; i >= 0; i--)
        begin
            acc = mul_mod(acc, acc, m);
            if (e[i])
                acc = mul_mod(acc, am, m);
        end
        return acc;
    endfunction

    function automatic logic proves_composite(logic [63:0] a, logic [63:0] n);
        logic [63:0] u;
        logic [63:0] d;
        logic [63:0] prev;
        int          r;
        u = (n - 64'd1) >> 1;
        r = 1;
        while (!u[0])
        begin
            r++;
            u = u >> 1;
        end
        d = pow_mod(a, u, n);
        for (int k = 0; k < r; k++)
        begin
            prev = d;
            d = mul_mod(d, d, n);
            if (d == 64'd1 && prev != 64'd1 && prev != n - 64'd1)
                return 1'b1;
        end
        return d != 64'd1;
    endfunction

    function automatic round_result_t predict_round(logic [63:0] n, logic [63:0] a, logic last);
        round_result_t res;
        logic          composite;
        if (n < 64'd2)
            res.verdict = mrw_pkg::VERDICT_COMPOS;
        else if (n == 64'd2 || n == 64'd3)
            res.verdict = mrw_pkg::VERDICT_PRIME;
        else if (!n[0])
            res.verdict = mrw_pkg::VERDICT_COMPOS;
        else if (proves_composite(a, n))
            res.verdict = mrw_pkg::VERDICT_WITNESS;
        else
            res.verdict = mrw_pkg::VERDICT_NONE;
        composite = composite_flag || res.verdict == mrw_pkg::VERDICT_WITNESS
                    || res.verdict == mrw_pkg::VERDICT_COMPOS;
        res.done = last;
        res.prime = last && !composite;
        composite_flag = last ? 1'b0 : composite;
        return res;
    endfunction

    task automatic send_request(logic [63:0] n, logic [63:0] a, logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tdata <= {a, n};
        s_tlast <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.insert(expected_results.size(), predict_round(n, a, last));
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64;
        return {$urandom, $urandom};
    endfunction

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    always @(posedge clk)
    begin
        round_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tdata=%h tlast=%b", m_tdata, m_tlast);
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[1:0] !== want.verdict || m_tdata[2] !== want.prime
                    || m_tlast !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected verdict=%0d prime=%b done=%b",
                                 want.verdict, want.prime, want.done);
                        $display("          got verdict=%0d prime=%b done=%b",
                                 m_tdata[1:0], m_tdata[2], m_tlast);
                    end
                end
            end
        end
    end

    task automatic test_trivial_candidates;
        send_request(64'd0, 64'd5, 1'b1);
        send_request(64'd1, 64'd0, 1'b1);
        send_request(64'd2, '1, 1'b1);
        send_request(64'd3, 64'd2, 1'b0);
        send_request(64'd2, 64'd7, 1'b1);
        send_request(64'd4, 64'd2, 1'b1);
        send_request(64'hFFFF_FFFF_FFFF_FFFE, 64'd3, 1'b1);
        send_request(64'd3, 64'd1, 1'b0);
        send_request(64'd0, 64'd1, 1'b0);
        send_request(64'd3, 64'd2, 1'b1);
    endtask

    task automatic test_directed_bases;
        send_request(64'd5, 64'd2, 1'b0);
        send_request(64'd7, 64'd3, 1'b1);
        send_request(64'd9, 64'd2, 1'b1);
        send_request(64'd561, 64'd2, 1'b1);
        send_request(64'd13, 64'd0, 1'b1);
        send_request(64'd13, 64'd1, 1'b0);
        send_request(64'd13, 64'd14, 1'b0);
        send_request(64'd13, 64'd12, 1'b1);
        send_request(64'd15, 64'd30, 1'b1);
        send_request('1, '1, 1'b1);
        send_request('1, 64'd2, 1'b1);
        send_request(64'hFFFF_FFFF_FFFF_FFC5, 64'd2, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFC5, '1, 1'b0);
        send_request(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFC4, 1'b1);
        send_request(64'd2047, 64'd2, 1'b1);
    endtask

    task automatic random_test;
        logic [63:0] primes[6];
        logic [63:0] n;
        int          bases;
        primes = '{64'd5, 64'd101, 64'd65537, 64'd2147483647,
                   64'hFFFF_FFFF_FFFF_FFC5, 64'd1000000007};
        case ($urandom_range(9))
            0: n = rand64();
            1: n = 64'($urandom_range(15));
            2, 3, 4: n = primes[$urandom_range(5)];
            default: n = rand64() | 64'd1;
        endcase
        bases = $urandom_range(1, 3);
        for (int i = 0; i < bases; i++)
            send_request(n, $urandom_range(3) == 0 ? rand64() : 64'd2 + 64'($urandom % 1000),
                         i == bases - 1 || $urandom_range(19) == 0);
    endtask

    task automatic test_random(int tests, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int t = 0; t < tests; t++)
            random_test();
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_off_cycles <= 30000;
        send_request(64'd101, 64'd3, 1'b0);
        send_request(64'd91, 64'd2, 1'b0);
        send_request(64'd97, 64'd5, 1'b1);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        composite_flag = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        mismatches = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_trivial_candidates();
        drain();
        test_directed_bases();
        drain();
        test_random(9, 0, 0);
        test_random(9, 83, 0);
        test_random(9, 0, 83);
        test_random(9, 17, 17);
        test_backpressure();
        if (mismatches == 0)
            $display("miller_rabin_witness regression: pass");
        else
            $display("miller_rabin_witness regression: fail");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("miller_rabin_witness regression: fail");
        $finish;
    end
endmodule
